@@ rtl/core/lwsp_pkg.sv @@
// Shared types, constants and helper functions of the live-wire path search core.
// Used by lwsp_engine and live_wire_shortest_path_core; no dependencies.
`timescale 1ns / 1ps
package lwsp_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int NPIX       = MAX_WIDTH * MAX_HEIGHT;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int IW    = XW + YW;
    localparam int CNTW  = IW + 1;
    localparam int DCW   = $clog2(IW + 1);
    localparam int CFGW  = 9;
    localparam int PIXW  = 16;
    localparam int COSTW = 16;
    localparam int DISTW = 32;
    localparam int NDIR  = 8;
    localparam int DIRW  = 3;
    localparam int LINKW = NDIR * COSTW;
    localparam int CMDW  = 2;
    localparam int CIDXW = 2;

    localparam logic [CMDW-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMDW-1:0] CMD_RUN   = 2'd1;
    localparam logic [CMDW-1:0] CMD_QUERY = 2'd2;

    localparam logic [CIDXW-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CIDXW-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_QRY_CHK,
        S_DIV,
        S_CLR,
        S_SEED,
        S_POP_RD0,
        S_POP_RD1,
        S_POP_TAKE,
        S_POP_LINK,
        S_SD_RD_L,
        S_SD_RD_R,
        S_SD_CHK,
        S_DONE_WR,
        S_REL_GEO,
        S_REL_MUL,
        S_REL_RD,
        S_REL_CHK,
        S_SU_RD,
        S_SU_CHK,
        S_RESP
    } state_t;

    // image size in use, already clamped to 1..MAX
    typedef struct packed {
        logic [XW:0] w;
        logic [YW:0] h;
    } geom_t;

    typedef struct packed {
        logic [CMDW-1:0]  cmd;
        logic [PIXW-1:0]  pixel_index;
        logic [LINKW-1:0] costs;
    } req_t;

    typedef struct packed {
        logic             status;
        logic [PIXW-1:0]  predecessor;
        logic [DISTW-1:0] path_cost;
    } rsp_t;

    typedef struct packed {
        logic             reached;
        logic             open;
        logic             done;
        logic [DISTW-1:0] cost;
        logic [IW-1:0]    pred;
    } node_t;

    typedef struct packed {
        logic [DISTW-1:0] cost;
        logic [IW-1:0]    idx;
        logic [YW-1:0]    y;
        logic [XW-1:0]    x;
        logic [IW-1:0]    pred;
    } heap_t;

    // heap order: lower cost first, then lower pixel index
    function automatic logic heap_before(input heap_t a, input heap_t b);
        logic res;
        if (a.cost != b.cost)
            res = a.cost < b.cost;
        else
            res = a.idx < b.idx;
        return res;
    endfunction

    function automatic logic signed [1:0] dir_dx(input logic [DIRW-1:0] d);
        logic signed [1:0] res;
        case (d)
            3'd0, 3'd3, 3'd5: res = -2'sd1;
            3'd1, 3'd6:       res = 2'sd0;
            default:          res = 2'sd1;
        endcase
        return res;
    endfunction

    function automatic logic signed [1:0] dir_dy(input logic [DIRW-1:0] d);
        logic signed [1:0] res;
        case (d)
            3'd0, 3'd1, 3'd2: res = -2'sd1;
            3'd3, 3'd4:       res = 2'sd0;
            default:          res = 2'sd1;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/core/lwsp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module lwsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/lwsp_engine.sv @@
// Command sequencer of the path search: link, node, heap and heap-position memories
// plus the read-modify-write state machine. Depends on lwsp_pkg and lwsp_ram.
`timescale 1ns / 1ps
module lwsp_engine
    import lwsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  geom_t geom,
    input  logic  req_valid,
    input  req_t  req,
    output logic  req_ready,
    output logic  rsp_valid,
    output rsp_t  rsp,
    input  logic  rsp_ready
);

    localparam int NODEW = $bits(node_t);
    localparam int HEAPW = $bits(heap_t);
    localparam int NPW   = XW + YW + 2;
    localparam int RW    = XW + YW + 1;

    state_t state_reg, state_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             search_ok_reg, search_ok_next;
    logic [IW-1:0]    idx_reg, idx_next;
    rsp_t             rsp_reg, rsp_next;
    logic [IW-1:0]    hole_reg, hole_next;
    heap_t            item_reg, item_next;
    heap_t            cur_reg, cur_next;
    heap_t            left_reg, left_next;
    logic [LINKW-1:0] link_reg, link_next;
    logic [DIRW-1:0]  dir_reg, dir_next;
    logic [XW-1:0]    nx_reg, nx_next;
    logic [YW-1:0]    ny_reg, ny_next;
    logic [IW-1:0]    r_reg, r_next;
    logic [IW-1:0]    clr_reg, clr_next;
    logic [IW-1:0]    dvd_reg, dvd_next;
    logic [XW:0]      rem_reg, rem_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;

    logic             link_we;
    logic [LINKW-1:0] link_rdata;
    logic             node_we;
    logic [IW-1:0]    node_waddr, node_raddr;
    node_t            node_wdata, node_rdata;
    logic             heap_we;
    logic [IW-1:0]    heap_waddr, heap_raddr;
    heap_t            heap_wdata, heap_rdata;
    logic [IW-1:0]    pos_rdata;

    logic [NPW-1:0]   npix;
    logic             in_image;
    logic [XW+1:0]    trial;
    logic             trial_ge;
    logic [XW+1:0]    trial_sub;
    logic [IW+1:0]    l_pos, r_pos, count_ext;
    logic [IW-1:0]    parent;
    logic [COSTW-1:0] link_sel;
    logic [DISTW:0]   cand_sum;
    logic [DISTW-1:0] cand;
    logic signed [XW+1:0] nx_s;
    logic signed [YW+1:0] ny_s;
    logic             nx_ok, ny_ok;
    logic [RW-1:0]    r_full;
    logic             advance;
    heap_t            new_item;
    heap_t            best;
    logic             take_left, take_right;

    lwsp_ram #(.WIDTH(LINKW), .DEPTH(NPIX)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (IW'(req.pixel_index)),
        .wdata (req.costs),
        .raddr (cur_reg.idx),
        .rdata (link_rdata)
    );

    lwsp_ram #(.WIDTH(NODEW), .DEPTH(NPIX)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    lwsp_ram #(.WIDTH(HEAPW), .DEPTH(NPIX)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    // every heap slot write also records where that pixel now sits
    lwsp_ram #(.WIDTH(IW), .DEPTH(NPIX)) u_pos_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_wdata.idx),
        .wdata (heap_waddr),
        .raddr (r_reg),
        .rdata (pos_rdata)
    );

    assign npix      = NPW'(geom.w) * NPW'(geom.h);
    assign in_image  = 32'(req.pixel_index) < 32'(npix);

    assign trial     = {rem_reg, dvd_reg[IW-1]};
    assign trial_ge  = trial >= {1'b0, geom.w};
    assign trial_sub = trial - {1'b0, geom.w};

    assign l_pos     = {1'b0, hole_reg, 1'b1};
    assign r_pos     = l_pos + (IW+2)'(1);
    assign count_ext = (IW+2)'(count_reg);
    assign parent    = IW'((hole_reg - IW'(1)) >> 1);

    assign link_sel  = link_reg[dir_reg*COSTW +: COSTW];
    assign cand_sum  = {1'b0, cur_reg.cost} + (DISTW+1)'(link_sel);
    assign cand      = cand_sum[DISTW] ? '1 : cand_sum[DISTW-1:0];

    assign nx_s  = $signed({2'b00, cur_reg.x}) + (XW+2)'(dir_dx(dir_reg));
    assign ny_s  = $signed({2'b00, cur_reg.y}) + (YW+2)'(dir_dy(dir_reg));
    assign nx_ok = !nx_s[XW+1] && (nx_s[XW:0] < geom.w);
    assign ny_ok = !ny_s[YW+1] && (ny_s[YW:0] < geom.h);

    assign r_full = RW'(ny_reg) * RW'(geom.w) + RW'(nx_reg);

    assign new_item = '{cost: cand, idx: r_reg, y: ny_reg, x: nx_reg, pred: cur_reg.idx};

    // smaller child of the sift-down hole, compared against the moving item
    always_comb
    begin
        take_left  = heap_before(left_reg, item_reg);
        best       = take_left ? left_reg : item_reg;
        take_right = (r_pos < count_ext) && heap_before(heap_rdata, best);
        if (take_right)
            best = heap_rdata;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign rsp       = rsp_reg;
    assign link_we   = (state_reg == S_IDLE) && req_valid && (req.cmd == CMD_LOAD) && in_image;
    assign node_raddr = (state_reg == S_IDLE) ? IW'(req.pixel_index) : r_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        search_ok_next = search_ok_reg;
        idx_next       = idx_reg;
        rsp_next       = rsp_reg;
        hole_next      = hole_reg;
        item_next      = item_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        link_next      = link_reg;
        dir_next       = dir_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        r_next         = r_reg;
        clr_next       = clr_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        node_we        = 1'b0;
        node_waddr     = r_reg;
        node_wdata     = '{reached: 1'b1, open: 1'b1, done: 1'b0, cost: cand,
                           pred: cur_reg.idx};
        heap_we        = 1'b0;
        heap_waddr     = hole_reg;
        heap_wdata     = item_reg;
        heap_raddr     = '0;
        advance        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    idx_next = IW'(req.pixel_index);
                    rsp_next = '{status: 1'b1, predecessor: '0, path_cost: '0};
                    state_next = S_RESP;
                    case (req.cmd)
                        CMD_LOAD:
                        begin
                            if (in_image)
                                rsp_next.status = 1'b0;
                        end
                        CMD_RUN:
                        begin
                            search_ok_next = 1'b0;
                            if (in_image)
                            begin
                                dvd_next     = IW'(req.pixel_index);
                                rem_next     = '0;
                                div_cnt_next = '0;
                                state_next   = S_DIV;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (search_ok_reg && (32'(req.pixel_index) < 32'(NPIX)))
                                state_next = S_QRY_CHK;
                        end
                        default:
                        begin
                            rsp_next.status = 1'b1;
                        end
                    endcase
                end
            end

            S_QRY_CHK:
            begin
                if (node_rdata.reached)
                    rsp_next = '{status: 1'b0, predecessor: PIXW'(node_rdata.pred),
                                 path_cost: node_rdata.cost};
                state_next = S_RESP;
            end

            S_DIV:
            begin
                // seed row and column, one quotient bit per cycle
                rem_next     = trial_ge ? trial_sub[XW:0] : trial[XW:0];
                dvd_next     = {dvd_reg[IW-2:0], trial_ge};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(IW - 1))
                begin
                    item_next = '{cost: '0, idx: idx_reg,
                                  y: YW'({dvd_reg[IW-2:0], trial_ge}),
                                  x: XW'(trial_ge ? trial_sub[XW:0] : trial[XW:0]),
                                  pred: idx_reg};
                    clr_next   = '0;
                    state_next = S_CLR;
                end
            end

            S_CLR:
            begin
                node_we    = 1'b1;
                node_waddr = clr_reg;
                node_wdata = '0;
                clr_next   = clr_reg + IW'(1);
                if (clr_reg == IW'(NPIX - 1))
                    state_next = S_SEED;
            end

            S_SEED:
            begin
                node_we        = 1'b1;
                node_waddr     = idx_reg;
                node_wdata     = '{reached: 1'b1, open: 1'b1, done: 1'b0, cost: '0,
                                   pred: idx_reg};
                heap_we        = 1'b1;
                heap_waddr     = '0;
                heap_wdata     = item_reg;
                count_next     = CNTW'(1);
                search_ok_next = 1'b1;
                state_next     = S_POP_RD0;
            end

            S_POP_RD0:
            begin
                if (count_reg == '0)
                begin
                    rsp_next   = '{status: 1'b0, predecessor: '0, path_cost: '0};
                    state_next = S_RESP;
                end
                else
                begin
                    heap_raddr = '0;
                    state_next = S_POP_RD1;
                end
            end

            S_POP_RD1:
            begin
                cur_next   = heap_rdata;
                heap_raddr = IW'(count_reg - CNTW'(1));
                state_next = S_POP_TAKE;
            end

            S_POP_TAKE:
            begin
                item_next  = heap_rdata;
                count_next = count_reg - CNTW'(1);
                hole_next  = '0;
                state_next = S_POP_LINK;
            end

            S_POP_LINK:
            begin
                link_next  = link_rdata;
                state_next = (count_reg == '0) ? S_DONE_WR : S_SD_RD_L;
            end

            S_SD_RD_L:
            begin
                if (l_pos >= count_ext)
                begin
                    heap_we    = 1'b1;
                    state_next = S_DONE_WR;
                end
                else
                begin
                    heap_raddr = IW'(l_pos);
                    state_next = S_SD_RD_R;
                end
            end

            S_SD_RD_R:
            begin
                left_next  = heap_rdata;
                heap_raddr = IW'(r_pos);
                state_next = S_SD_CHK;
            end

            S_SD_CHK:
            begin
                heap_we = 1'b1;
                if (!take_left && !take_right)
                begin
                    state_next = S_DONE_WR;
                end
                else
                begin
                    heap_wdata = best;
                    hole_next  = take_right ? IW'(r_pos) : IW'(l_pos);
                    state_next = S_SD_RD_L;
                end
            end

            S_DONE_WR:
            begin
                node_we    = 1'b1;
                node_waddr = cur_reg.idx;
                node_wdata = '{reached: 1'b1, open: 1'b0, done: 1'b1, cost: cur_reg.cost,
                               pred: cur_reg.pred};
                dir_next   = '0;
                state_next = S_REL_GEO;
            end

            S_REL_GEO:
            begin
                if (nx_ok && ny_ok)
                begin
                    nx_next    = XW'(nx_s);
                    ny_next    = YW'(ny_s);
                    state_next = S_REL_MUL;
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            S_REL_MUL:
            begin
                r_next     = IW'(r_full);
                state_next = S_REL_RD;
            end

            S_REL_RD:
            begin
                state_next = S_REL_CHK;
            end

            S_REL_CHK:
            begin
                if (node_rdata.done)
                begin
                    advance = 1'b1;
                end
                else if (node_rdata.open)
                begin
                    if (cand < node_rdata.cost)
                    begin
                        node_we    = 1'b1;
                        item_next  = new_item;
                        hole_next  = pos_rdata;
                        state_next = S_SU_RD;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
                else
                begin
                    node_we    = 1'b1;
                    item_next  = new_item;
                    hole_next  = IW'(count_reg);
                    count_next = count_reg + CNTW'(1);
                    state_next = S_SU_RD;
                end
            end

            S_SU_RD:
            begin
                if (hole_reg == '0)
                begin
                    heap_we = 1'b1;
                    advance = 1'b1;
                end
                else
                begin
                    heap_raddr = parent;
                    state_next = S_SU_CHK;
                end
            end

            S_SU_CHK:
            begin
                heap_we = 1'b1;
                if (heap_before(item_reg, heap_rdata))
                begin
                    heap_wdata = heap_rdata;
                    hole_next  = parent;
                    state_next = S_SU_RD;
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            S_RESP:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next direction, or back to the heap once all eight are seen
        if (advance)
        begin
            if (dir_reg == DIRW'(NDIR - 1))
            begin
                state_next = S_POP_RD0;
            end
            else
            begin
                dir_next   = dir_reg + DIRW'(1);
                state_next = S_REL_GEO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            search_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            search_ok_reg <= search_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        rsp_reg     <= rsp_next;
        hole_reg    <= hole_next;
        item_reg    <= item_next;
        cur_reg     <= cur_next;
        left_reg    <= left_next;
        link_reg    <= link_next;
        dir_reg     <= dir_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        r_reg       <= r_next;
        clr_reg     <= clr_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
    end

endmodule

@@ rtl/core/live_wire_shortest_path_core.sv @@
// Top level of the live-wire path search: stream ports, configuration registers,
// output register. Depends on lwsp_pkg, lwsp_engine and lwsp_ram.
`timescale 1ns / 1ps
// Usage
//   s_*   : command stream. s_tuser carries the command (load, run, query),
//           s_tdata the pixel index and the eight link costs of a load.
//   m_*   : one result per command. m_tuser is the status flag (0 ok, 1 not
//           reached, rejected or no search), m_tdata predecessor and path cost.
//   cfg_* : register writes (image width, image height); always ready, apply
//           only while no command is in flight.
// Timing
//   Commands are handled one at a time; s_tready is high only while the core
//   is idle. A load answers straight from idle, a query after a node memory read.
//   A run first divides the seed index by the width, bit by bit, then clears
//   the node memory, one entry per cycle, then runs the heap search. Each
//   popped pixel costs a pop and sift-down, plus up to 8 relaxations with a
//   sift-up each where needed; the single read port of the heap memory makes
//   these walks go one heap read at a time.
// Reset and stall
//   Reset returns the core to idle with no search result held and the image
//   size at 256 x 256. The result waits in the output register while m_tready
//   is low; the core may take the next command meanwhile but holds its own
//   result until the register frees up.
module live_wire_shortest_path_core
    import lwsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [143:0]     s_tdata,  // pixel_index, cost_up_left, cost_up, cost_up_right,
                                       // cost_left, cost_right, cost_down_left, cost_down,
                                       // cost_down_right
    input  logic [CMDW-1:0]  s_tuser,  // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,  // predecessor, path_cost
    output logic             m_tuser,  // status
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CIDXW-1:0] cfg_index,
    input  logic [CFGW-1:0]  cfg_data
);

    logic [CFGW-1:0] width_cfg_reg, width_cfg_next;
    logic [CFGW-1:0] height_cfg_reg, height_cfg_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_reg, out_next;

    geom_t geom;
    req_t  req;
    rsp_t  rsp;
    logic  rsp_valid;
    logic  rsp_ready;

    // clamp the programmed size into 1..MAX
    function automatic logic [XW:0] clamp_w(input logic [CFGW-1:0] raw);
        logic [XW:0] res;
        if (32'(raw) > MAX_WIDTH)
            res = (XW+1)'(MAX_WIDTH);
        else if (raw == '0)
            res = (XW+1)'(1);
        else
            res = (XW+1)'(raw);
        return res;
    endfunction

    function automatic logic [YW:0] clamp_h(input logic [CFGW-1:0] raw);
        logic [YW:0] res;
        if (32'(raw) > MAX_HEIGHT)
            res = (YW+1)'(MAX_HEIGHT);
        else if (raw == '0)
            res = (YW+1)'(1);
        else
            res = (YW+1)'(raw);
        return res;
    endfunction

    assign geom.w = clamp_w(width_cfg_reg);
    assign geom.h = clamp_h(height_cfg_reg);

    assign req.cmd         = s_tuser;
    assign req.pixel_index = s_tdata[15:0];
    assign req.costs       = s_tdata[143:16];

    lwsp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (s_tready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rsp_ready (rsp_ready)
    );

    // free the output slot when empty or when its transfer completes this cycle
    assign rsp_ready = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_cfg_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_cfg_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (rsp_ready)
        begin
            // drop the delivered result, load a new one if ready
            out_valid_next = rsp_valid;
            if (rsp_valid)
                out_next = rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFGW'(MAX_WIDTH);
            height_cfg_reg <= CFGW'(MAX_HEIGHT);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.path_cost, out_reg.predecessor};

endmodule
